[src/qpr_pkg.sv]
// Shared constants and derived widths for the quaternion point rotation pipeline.
// No dependencies; imported by the top level, its port checker and the testbench.
package qpr_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int MATRIX_FRAC_BITS = 16;
    localparam int REF_FRAC_BITS    = 16;
    localparam int REF_ENTRY_BITS   = 18;
    localparam int QUAT_BITS        = 16;

    localparam int REF_ROW_BITS = 3 * REF_ENTRY_BITS;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

    // identity at reset
    localparam logic [REF_ROW_BITS-1:0] RST_ROW0 =
        REF_ROW_BITS'(64'(1) << REF_FRAC_BITS);
    localparam logic [REF_ROW_BITS-1:0] RST_ROW1 =
        REF_ROW_BITS'(64'(1) << (REF_FRAC_BITS + REF_ENTRY_BITS));
    localparam logic [REF_ROW_BITS-1:0] RST_ROW2 =
        REF_ROW_BITS'(64'(1) << (REF_FRAC_BITS + 2 * REF_ENTRY_BITS));

    // datapath widths
    localparam int NUM_W = 2 * QUAT_BITS + 3;              // rotation numerators
    localparam int N2_W  = 2 * QUAT_BITS + 1;              // squared norm
    localparam int QB    = MATRIX_FRAC_BITS + 1;           // quotient bits
    localparam int DIV_W = NUM_W + QB;                     // divider remainder
    localparam int ROT_W = MATRIX_FRAC_BITS + 2;
    localparam int CP_W  = REF_ENTRY_BITS + ROT_W;
    localparam int CS_W  = CP_W + 2;
    localparam int CM_W  = CS_W - REF_FRAC_BITS;
    localparam int PP_W  = CM_W + COORD_WIDTH;
    localparam int PS_W  = PP_W + 2;
    localparam int SV_W  = PS_W - MATRIX_FRAC_BITS;

    // stream widths
    localparam int IN_W   = 4 * QUAT_BITS + 3 * COORD_WIDTH;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 3 * COORD_WIDTH;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int USER_W = 2;

    // pipeline stage indexes
    localparam int S_IN   = 0;
    localparam int S_PRD  = 1;
    localparam int S_SUM  = 2;
    localparam int S_DIV0 = 3;
    localparam int S_ROT  = S_DIV0 + QB + 1;
    localparam int S_CPR  = S_ROT + 1;
    localparam int S_CM   = S_CPR + 1;
    localparam int S_PPR  = S_CM + 1;
    localparam int S_OUT  = S_PPR + 1;
    localparam int NST    = S_OUT + 1;

    typedef logic signed [QUAT_BITS-1:0]      t_quat;
    typedef logic signed [COORD_WIDTH-1:0]    t_coord;
    typedef logic signed [REF_ENTRY_BITS-1:0] t_ref;

endpackage

[src/quaternion_point_rotation_top.sv]
// Quaternion point rotation: normalised rotation matrix, reference premultiply, point rotate.
// Depends on qpr_pkg.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    quaternion x,y,z,w + point x,y,z
//  m_axis    out  m_axis_tvalid/m_axis_tready    east,north,up (tdata), valid,sat (tuser)
//  cfg       in   i_cfg_wen                      reference row index + 54-bit row
//
// One beat per clock unless the output stalls; NST (26) register stages, 17 of which are the
// restoring divider that produces one quotient bit per stage for all nine entries.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall freezes every stage in place. Reset clears valid bits and the reference
// rows (identity); payload registers are not reset.
module quaternion_point_rotation_top import qpr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, point_x, point_y, point_z
    input  logic [IN_TW-1:0]        s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // out_east, out_north, out_up
    output logic [OUT_TW-1:0]       m_axis_tdata,
    // valid_res, saturated
    output logic [USER_W-1:0]       m_axis_tuser,
    input  logic                    i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [REF_ROW_BITS-1:0] i_cfg_data
);

    logic en;
    logic [NST-1:0] r_vld;
    logic [REF_ROW_BITS-1:0] r_ref_row [3];
    t_ref ref_e [3][3];

    assign en            = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NST-1];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_row[0] <= RST_ROW0;
            r_ref_row[1] <= RST_ROW1;
            r_ref_row[2] <= RST_ROW2;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_ROW0: r_ref_row[0] <= i_cfg_data;
                REG_ROW1: r_ref_row[1] <= i_cfg_data;
                REG_ROW2: r_ref_row[2] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                ref_e[i][k] = r_ref_row[i][k*REF_ENTRY_BITS +: REF_ENTRY_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // ---------------- input, products, sums ----------------
    t_quat  r_q [4];
    t_coord r_pt [S_IN:S_CM][3];
    logic signed [2*QUAT_BITS-1:0] r_sq [4];   // x2 y2 z2 w2
    logic signed [2*QUAT_BITS-1:0] r_cr [6];   // xy wz xz wy yz wx
    logic [N2_W-1:0]          r_n2;
    logic signed [NUM_W-1:0]  r_num [9];
    logic                     r_zf [S_SUM:S_PPR];

    logic [N2_W-1:0]          n_n2;
    logic signed [NUM_W-1:0]  n_num [9];
    logic                     n_zf;

    always_comb begin
        logic signed [NUM_W-1:0] e_x2, e_y2, e_z2, e_w2, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
        logic signed [NUM_W-1:0] n2s;
        e_x2 = NUM_W'(r_sq[0]);
        e_y2 = NUM_W'(r_sq[1]);
        e_z2 = NUM_W'(r_sq[2]);
        e_w2 = NUM_W'(r_sq[3]);
        e_xy = NUM_W'(r_cr[0]);
        e_wz = NUM_W'(r_cr[1]);
        e_xz = NUM_W'(r_cr[2]);
        e_wy = NUM_W'(r_cr[3]);
        e_yz = NUM_W'(r_cr[4]);
        e_wx = NUM_W'(r_cr[5]);
        n2s  = e_x2 + e_y2 + e_z2 + e_w2;
        n_n2 = n2s[N2_W-1:0];
        n_zf = (n2s == '0);
        n_num[0] = e_w2 + e_x2 - e_y2 - e_z2;
        n_num[1] = (e_xy - e_wz) <<< 1;
        n_num[2] = (e_xz + e_wy) <<< 1;
        n_num[3] = (e_xy + e_wz) <<< 1;
        n_num[4] = e_w2 - e_x2 + e_y2 - e_z2;
        n_num[5] = (e_yz - e_wx) <<< 1;
        n_num[6] = (e_xz - e_wy) <<< 1;
        n_num[7] = (e_yz + e_wx) <<< 1;
        n_num[8] = e_w2 - e_x2 - e_y2 + e_z2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_q[c] <= s_axis_tdata[c*QUAT_BITS +: QUAT_BITS];
            end
            for (int c = 0; c < 3; c++) begin
                r_pt[S_IN][c] <= s_axis_tdata[4*QUAT_BITS + c*COORD_WIDTH +: COORD_WIDTH];
            end
            for (int s = S_IN + 1; s <= S_CM; s++) begin
                r_pt[s] <= r_pt[s-1];
            end
            for (int c = 0; c < 4; c++) begin
                r_sq[c] <= r_q[c] * r_q[c];
            end
            r_cr[0] <= r_q[0] * r_q[1];
            r_cr[1] <= r_q[3] * r_q[2];
            r_cr[2] <= r_q[0] * r_q[2];
            r_cr[3] <= r_q[3] * r_q[1];
            r_cr[4] <= r_q[1] * r_q[2];
            r_cr[5] <= r_q[3] * r_q[0];
            r_n2  <= n_n2;
            r_num <= n_num;
            r_zf[S_SUM] <= n_zf;
            for (int s = S_SUM + 1; s <= S_PPR; s++) begin
                r_zf[s] <= r_zf[s-1];
            end
        end
    end

    // ---------------- divider: round(|num| * 2^F / n2) ----------------
    // dividend |num|*2^(F+1) + n2 over divisor 2*n2 gives the rounded quotient directly
    logic [DIV_W-1:0] r_rem [S_DIV0:S_DIV0+QB-1][9];
    logic [DIV_W-1:0] r_dv  [S_DIV0:S_DIV0+QB-1];
    logic [QB-1:0]    r_quo [S_DIV0+1:S_DIV0+QB][9];
    logic             r_neg [S_DIV0:S_DIV0+QB][9];

    logic [DIV_W-1:0] n_rem0 [9];
    logic             n_neg0 [9];

    always_comb begin
        logic [NUM_W-1:0] mag;
        for (int k = 0; k < 9; k++) begin
            n_neg0[k] = r_num[k][NUM_W-1];
            mag       = n_neg0[k] ? NUM_W'(-r_num[k]) : NUM_W'(r_num[k]);
            n_rem0[k] = {mag, {QB{1'b0}}} + DIV_W'(r_n2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[S_DIV0] <= n_rem0;
            r_neg[S_DIV0] <= n_neg0;
            r_dv[S_DIV0]  <= DIV_W'({r_n2, 1'b0});
            for (int s = S_DIV0 + 1; s <= S_DIV0 + QB; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_div
        localparam int IDX = S_DIV0 + g;
        localparam int B   = QB - g;
        logic [DIV_W-1:0] n_rem [9];
        logic             n_bit [9];
        logic [DIV_W-1:0] n_sh;

        always_comb begin
            n_sh = r_dv[IDX-1] << B;
            for (int k = 0; k < 9; k++) begin
                n_bit[k] = r_rem[IDX-1][k] >= n_sh;
                n_rem[k] = n_bit[k] ? r_rem[IDX-1][k] - n_sh : r_rem[IDX-1][k];
            end
        end

        if (g == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int k = 0; k < 9; k++) begin
                        r_quo[IDX][k] <= QB'(n_bit[k]);
                    end
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int k = 0; k < 9; k++) begin
                        r_quo[IDX][k] <= {r_quo[IDX-1][k][QB-2:0], n_bit[k]};
                    end
                end
            end
        end

        if (g < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[IDX] <= n_rem;
                    r_dv[IDX]  <= r_dv[IDX-1];
                end
            end
        end
    end

    // ---------------- matrix product C = REF * R ----------------
    logic signed [ROT_W-1:0] r_rot [9];
    logic signed [CP_W-1:0]  r_cp  [3][3][3];
    logic signed [CM_W-1:0]  r_cm  [3][3];
    logic signed [ROT_W-1:0] n_rot [9];
    logic signed [CP_W-1:0]  n_cp  [3][3][3];
    logic signed [CM_W-1:0]  n_cm  [3][3];

    localparam logic signed [CS_W-1:0] C_HALF = CS_W'(1) <<< (REF_FRAC_BITS - 1);

    always_comb begin
        logic signed [ROT_W-1:0] q;
        logic signed [CS_W-1:0]  acc, t;
        for (int k = 0; k < 9; k++) begin
            q        = {1'b0, r_quo[S_DIV0+QB][k]};
            n_rot[k] = r_neg[S_DIV0+QB][k] ? -q : q;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    n_cp[i][j][k] = CP_W'(ref_e[i][k]) * CP_W'(r_rot[k*3+j]);
                end
                acc = CS_W'(r_cp[i][j][0]) + CS_W'(r_cp[i][j][1]) + CS_W'(r_cp[i][j][2]);
                // ties away from zero
                t   = acc + (acc[CS_W-1] ? C_HALF - CS_W'(1) : C_HALF);
                n_cm[i][j] = t[CS_W-1:REF_FRAC_BITS];
            end
        end
    end

    // ---------------- point rotation, rounding, saturation ----------------
    logic signed [PP_W-1:0] r_pp [3][3];
    logic signed [PP_W-1:0] n_pp [3][3];
    t_coord r_out [3];
    logic   r_ok, r_sat;
    t_coord n_out [3];
    logic   n_sat;

    localparam logic signed [PS_W-1:0] P_HALF = PS_W'(1) <<< (MATRIX_FRAC_BITS - 1);
    localparam logic signed [SV_W-1:0] V_MAX  = SV_W'((64'(1) << (COORD_WIDTH - 1)) - 1);
    localparam logic signed [SV_W-1:0] V_MIN  = -V_MAX - SV_W'(1);

    always_comb begin
        logic signed [PS_W-1:0] acc, t;
        logic signed [SV_W-1:0] v;
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pp[i][j] = PP_W'(r_cm[i][j]) * PP_W'(r_pt[S_CM][j]);
            end
            acc = PS_W'(r_pp[i][0]) + PS_W'(r_pp[i][1]) + PS_W'(r_pp[i][2]);
            t   = acc + (acc[PS_W-1] ? P_HALF - PS_W'(1) : P_HALF);
            v   = t[PS_W-1:MATRIX_FRAC_BITS];
            if (v > V_MAX) begin
                n_out[i] = V_MAX[COORD_WIDTH-1:0];
                n_sat    = 1'b1;
            end else if (v < V_MIN) begin
                n_out[i] = V_MIN[COORD_WIDTH-1:0];
                n_sat    = 1'b1;
            end else begin
                n_out[i] = v[COORD_WIDTH-1:0];
            end
            if (r_zf[S_PPR]) begin
                n_out[i] = '0;
            end
        end
        if (r_zf[S_PPR]) begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot <= n_rot;
            r_cp  <= n_cp;
            r_cm  <= n_cm;
            r_pp  <= n_pp;
            r_out <= n_out;
            r_sat <= n_sat;
            r_ok  <= !r_zf[S_PPR];
        end
    end

    assign m_axis_tdata = OUT_TW'({r_out[2], r_out[1], r_out[0]});
    assign m_axis_tuser = {r_sat, r_ok};

endmodule

[src/qpr_checker.sv]
// Port-level checks for quaternion_point_rotation_top, attached by bind.
// Depends on qpr_pkg.
module qpr_checker import qpr_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [IN_TW-1:0]        s_axis_tdata,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OUT_TW-1:0]       m_axis_tdata,
    input logic [USER_W-1:0]       m_axis_tuser,
    input logic                    i_cfg_wen,
    input logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input logic [REF_ROW_BITS-1:0] i_cfg_data
);

    // held beat must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // rejected quaternion: zero coordinates, no saturation
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("invalid result carries data");

    // pipeline moves exactly when the output slot frees
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output slot");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind quaternion_point_rotation_top qpr_checker u_qpr_checker (.*);

[sim/testbench.sv]
// Self-checking bench for quaternion_point_rotation_top: random and directed beats,
// predicted results compared field by field. Depends on qpr_pkg and the top level.
module testbench import qpr_pkg::*; ();

    typedef struct packed {
        logic [0:0] valid_res;
        logic [0:0] sat;
        t_coord     east;
        t_coord     north;
        t_coord     up;
    } t_rotated;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;
    logic i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [REF_ROW_BITS-1:0] i_cfg_data = '0;

    logic [REF_ROW_BITS-1:0] ref_rows [3];
    t_rotated expected_q [$];
    int errors = 0;
    int beats_sent = 0;
    int beats_seen = 0;
    int n_invalid = 0;
    int n_sat = 0;
    bit calm = 1'b0;

    quaternion_point_rotation_top i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #400_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // round to nearest, ties away from zero
    function automatic longint rnd_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic t_rotated rotate_point(t_quat qx, t_quat qy, t_quat qz, t_quat qw,
                                              t_coord px, t_coord py, t_coord pz);
        longint x, y, z, w, n2, a, m, acc, v, maxv;
        longint num [9];
        longint rot [9];
        longint cm [9];
        longint p [3];
        t_rotated r;
        x = qx; y = qy; z = qz; w = qw;
        p[0] = px; p[1] = py; p[2] = pz;
        r = '0;
        n2 = x*x + y*y + z*z + w*w;
        if (n2 == 0) return r;
        num[0] = w*w + x*x - y*y - z*z;  num[1] = 2*(x*y - w*z);  num[2] = 2*(x*z + w*y);
        num[3] = 2*(x*y + w*z);  num[4] = w*w - x*x + y*y - z*z;  num[5] = 2*(y*z - w*x);
        num[6] = 2*(x*z - w*y);  num[7] = 2*(y*z + w*x);  num[8] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 9; i++) begin
            a = num[i] <<< MATRIX_FRAC_BITS;
            m = (a < 0) ? -a : a;
            m = (2*m + n2) / (2*n2);
            rot[i] = (a < 0) ? -m : m;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += longint'(t_ref'(ref_rows[i][k*REF_ENTRY_BITS +: REF_ENTRY_BITS]))
                           * rot[k*3 + j];
                cm[i*3 + j] = rnd_shift(acc, REF_FRAC_BITS);
            end
        maxv = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        r.valid_res = 1'b1;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += cm[i*3 + j] * p[j];
            v = rnd_shift(acc, MATRIX_FRAC_BITS);
            if (v > maxv) begin v = maxv; r.sat = 1'b1; end
            if (v < -maxv - 1) begin v = -maxv - 1; r.sat = 1'b1; end
            if (i == 0) r.east = t_coord'(v);
            else if (i == 1) r.north = t_coord'(v);
            else r.up = t_coord'(v);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch beat %0d %s: got %0d expected %0d", beats_seen, what, got, want);
    endtask

    // valid stays high into the next beat; it drops only while idling or draining
    task automatic send_beat(t_quat qx, t_quat qy, t_quat qz, t_quat qw,
                             t_coord px, t_coord py, t_coord pz);
        while (!calm && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= IN_TW'({pz, py, px, qw, qz, qy, qx});
        s_axis_tvalid <= 1'b1;
        expected_q.push_back(rotate_point(qx, qy, qz, qw, px, py, pz));
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [REF_ROW_BITS-1:0] row);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= row;
        if (idx <= REG_ROW2) ref_rows[idx] = row;
        @(negedge i_clk);
    endtask

    task automatic drain;
        int guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (NST + 4) @(negedge i_clk);
    endtask

    function automatic t_quat rand_quat_part();
        case ($urandom_range(4))
            0: return t_quat'($urandom_range(3) - 1);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return t_quat'($urandom);
        endcase
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            1: return t_coord'($urandom_range(2000)) - 24'sd1000;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic logic [REF_ROW_BITS-1:0] rand_row();
        logic [REF_ROW_BITS-1:0] r;
        for (int k = 0; k < 3; k++)
            case ($urandom_range(3))
                0: r[k*REF_ENTRY_BITS +: REF_ENTRY_BITS] = 18'h10000;
                1: r[k*REF_ENTRY_BITS +: REF_ENTRY_BITS] = 18'h30000;
                default: r[k*REF_ENTRY_BITS +: REF_ENTRY_BITS] = 18'($urandom);
            endcase
        return r;
    endfunction

    task automatic test_directed;
        send_beat(0, 0, 0, 0, 24'sd5, -24'sd7, 24'sd9);            // zero quaternion
        send_beat(0, 0, 0, 16'sh7fff, 24'sd1000, -24'sd2000, 24'sd3000);
        send_beat(0, 0, 0, 16'sh8000, 24'sh7fffff, 24'sh800000, 24'sd1);
        send_beat(16'sh7fff, 0, 0, 0, 24'sd1, 24'sd2, 24'sd3);
        send_beat(0, 16'sh8000, 0, 0, 24'sd1, 24'sd2, 24'sd3);
        send_beat(0, 0, 16'sh7fff, 0, 24'sd1, 24'sd2, 24'sd3);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  24'sh800000, 24'sh800000, 24'sh800000);
        send_beat(0, 0, 0, 16'sd1, -24'sd1, 24'sd0, 24'sd1);       // tiny non-unit norm
        send_beat(16'sd1, -16'sd1, 16'sd1, -16'sd1, 24'sd333, 24'sd0, -24'sd333);
        send_beat(16'sh5a82, 0, 0, 16'sh5a82, 24'sh7fffff, 24'sh7fffff, 24'sd0);
        send_beat(0, 0, 16'sh5a82, 16'sha57e, 24'sh800000, 24'sd0, 24'sh7fffff);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_beat(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
                      rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_reference(logic [REF_ROW_BITS-1:0] r0, logic [REF_ROW_BITS-1:0] r1,
                                  logic [REF_ROW_BITS-1:0] r2, int count);
        drain();
        write_row(REG_ROW0, r0);
        write_row(REG_ROW1, r1);
        write_row(REG_ROW2, r2);
        write_row(2'd3, rand_row());                               // unmapped index
        i_cfg_wen <= 1'b0;
        test_directed();
        test_random(count);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rotated want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("unexpected result beat %0d", beats_seen);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tuser[0] !== want.valid_res)
                    report_mismatch("valid_res", m_axis_tuser[0], want.valid_res);
                if (m_axis_tuser[1] !== want.sat)
                    report_mismatch("saturated", m_axis_tuser[1], want.sat);
                if (m_axis_tdata[0 +: COORD_WIDTH] !== want.east)
                    report_mismatch("east", t_coord'(m_axis_tdata[0 +: COORD_WIDTH]), want.east);
                if (m_axis_tdata[COORD_WIDTH +: COORD_WIDTH] !== want.north)
                    report_mismatch("north",
                        t_coord'(m_axis_tdata[COORD_WIDTH +: COORD_WIDTH]), want.north);
                if (m_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH] !== want.up)
                    report_mismatch("up",
                        t_coord'(m_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]), want.up);
                if (!want.valid_res) n_invalid++;
                if (want.sat) n_sat++;
            end
        end
    end

    // output stalls
    always @(negedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 26);

    initial begin
        ref_rows[0] = RST_ROW0;
        ref_rows[1] = RST_ROW1;
        ref_rows[2] = RST_ROW2;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(120);
        test_reference({18'h1ffff, 18'h1ffff, 18'h1ffff}, {18'h20000, 18'h20000, 18'h20000},
                       {18'h3ffff, 18'h00001, 18'h00000}, 80);
        test_reference({18'h20000, 18'h0, 18'h0}, {18'h0, 18'h1ffff, 18'h0},
                       {18'h0, 18'h0, 18'h20000}, 80);
        calm = 1'b1;                                               // back-to-back stretch
        test_reference(RST_ROW0, RST_ROW1, RST_ROW2, 120);
        calm = 1'b0;
        test_reference(rand_row(), rand_row(), rand_row(), 80);
        test_reference(rand_row(), rand_row(), rand_row(), 60);
        drain();
        if (expected_q.size() != 0) begin
            errors++;
            $display("%0d results never arrived", expected_q.size());
        end
        $display("sent %0d beats over six reference settings; %0d zero-norm, %0d saturated",
                 beats_sent, n_invalid, n_sat);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
